@@ rtl/dcff_pkg.sv @@
`default_nettype none
package dcff_pkg;

	localparam int COEF_SLOTS = 64;
	localparam int COEF_W     = 8;

	localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_SLOTS] = '{
		-8'sd1,   8'sd0,   8'sd1,  -8'sd1,  -8'sd4,  -8'sd2,   8'sd6,   8'sd9,
		-8'sd7,  -8'sd25, -8'sd5,   8'sd62,  8'sd127, 8'sd127, 8'sd62, -8'sd5,
		-8'sd25, -8'sd7,   8'sd9,   8'sd6,  -8'sd2,  -8'sd4,  -8'sd1,   8'sd1,
		8'sd0,   -8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
		8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
		8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
		8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
		8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0
	};

	// channel codes
	localparam logic CH_X = 1'b0;
	localparam logic CH_Y = 1'b1;

	// token: a shift request to every cell, or the tag of a partial sum moving along the cell row
	typedef struct packed {
		logic vld;
		logic ch;
	} tok_t;

endpackage
`default_nettype wire

@@ rtl/dcff_cell.sv @@
`default_nettype none
module dcff_cell #(
	parameter int SAMPLE_BITS = 8,
	parameter int ACC_W       = 18
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dcff_pkg::tok_t                    shift,
	input  wire logic [SAMPLE_BITS-1:0]            x_in,
	input  wire logic [SAMPLE_BITS-1:0]            y_in,
	output logic      [SAMPLE_BITS-1:0]            x_q,
	output logic      [SAMPLE_BITS-1:0]            y_q,
	input  wire logic signed [dcff_pkg::COEF_W-1:0] coef,
	input  wire dcff_pkg::tok_t                    tok_in,
	input  wire logic signed [ACC_W-1:0]           acc_in,
	output dcff_pkg::tok_t                         tok_q,
	output logic signed [ACC_W-1:0]                acc_q
);

	logic [SAMPLE_BITS-1:0] sel;
	logic signed [ACC_W-1:0] prod;

	assign sel  = (tok_in.ch == dcff_pkg::CH_Y) ? y_q : x_q;
	assign prod = ACC_W'(coef) * ACC_W'($signed({1'b0, sel}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (shift.vld) begin
			if (shift.ch == dcff_pkg::CH_Y) begin
				y_q <= y_in;
			end else begin
				x_q <= x_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_in + prod;
	end

endmodule
`default_nettype wire

@@ rtl/dual_channel_fir_framer_unit.sv @@
// An input transfer is registered in start_q, then passes the TAPS cell registers and
// the output register before out_valid. The partial sum walks the row of TAPS cells
// one cell per cycle, and one item is in the row at a time.
// A finished result may wait in the output stage while the next item is taken.
// Reset (arst_n low, asynchronous): delay lines cleared, filtering on, channel X next.
`default_nettype none
module dual_channel_fir_framer_unit #(
	parameter int TAPS        = 26,
	parameter int SAMPLE_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        sample,
	input  wire logic              button_pressed,
	input  wire logic              digital_a,
	input  wire logic              digital_b,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             frame_first,
	output logic [7:0]             frame_second,
	output logic [7:0]             frame_third,
	output logic signed [15:0]     filtered_value,
	output logic                   channel_out
);

	localparam int ACC_W = SAMPLE_BITS + 10;
	localparam int SAT_W = (ACC_W > 16) ? ACC_W : 17;
	localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
	localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(32768);
	localparam logic [1:0] SYNC_SECOND = 2'b10;
	localparam logic [1:0] SYNC_THIRD  = 2'b01;

	typedef struct packed {
		logic [7:0]        f1;
		logic [7:0]        f2;
		logic [7:0]        f3;
		logic signed [15:0] value;
		logic              ch;
	} res_t;

	logic in_fire, out_take, done;
	logic busy_q, nxt_ch_q, en_q;
	logic pass_q, da_q, db_q;
	logic [SAMPLE_BITS-1:0] smp, raw_q;
	dcff_pkg::tok_t start_q, shift;
	logic out_v_q, hold_v_q;
	res_t out_q, hold_q, res;
	logic signed [SAT_W-1:0] acc_ext;
	logic signed [15:0] sat_val, value;

	logic [SAMPLE_BITS-1:0] x_w [TAPS];
	logic [SAMPLE_BITS-1:0] y_w [TAPS];
	dcff_pkg::tok_t         tok_w [TAPS];
	logic signed [ACC_W-1:0] acc_w [TAPS];

	generate
		if (SAMPLE_BITS >= 8) begin : g_wide
			assign smp = SAMPLE_BITS'(sample);
		end else begin : g_narrow
			assign smp = sample[SAMPLE_BITS-1:0];
		end
	endgenerate

	assign in_ready  = !busy_q && !hold_v_q;
	assign in_fire   = in_valid && in_ready;
	assign out_take  = out_v_q && out_ready;
	assign shift     = '{vld: in_fire, ch: nxt_ch_q};

	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_cell
			if (k == 0) begin : g_head
				dcff_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.x_in   (smp),
					.y_in   (smp),
					.x_q    (x_w[k]),
					.y_q    (y_w[k]),
					.coef   (dcff_pkg::COEF_TABLE[k]),
					.tok_in (start_q),
					.acc_in ('0),
					.tok_q  (tok_w[k]),
					.acc_q  (acc_w[k])
				);
			end else begin : g_body
				dcff_cell #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.x_in   (x_w[k-1]),
					.y_in   (y_w[k-1]),
					.x_q    (x_w[k]),
					.y_q    (y_w[k]),
					.coef   (dcff_pkg::COEF_TABLE[k]),
					.tok_in (tok_w[k-1]),
					.acc_in (acc_w[k-1]),
					.tok_q  (tok_w[k]),
					.acc_q  (acc_w[k])
				);
			end
		end
	endgenerate

	assign done    = tok_w[TAPS-1].vld;
	assign acc_ext = SAT_W'(acc_w[TAPS-1]);

	always_comb begin
		if (acc_ext > SAT_MAX) begin
			sat_val = 16'sd32767;
		end else if (acc_ext < SAT_MIN) begin
			sat_val = -16'sd32768;
		end else begin
			sat_val = acc_ext[15:0];
		end
		value     = pass_q ? $signed(16'(raw_q)) : sat_val;
		res.value = value;
		res.ch    = tok_w[TAPS-1].ch;
		res.f1    = {1'b1, tok_w[TAPS-1].ch, da_q, db_q, value[15:12]};
		res.f2    = {SYNC_SECOND, value[11:6]};
		res.f3    = {SYNC_THIRD, value[5:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			nxt_ch_q <= dcff_pkg::CH_X;
			en_q     <= 1'b1;
			start_q  <= '0;
		end else begin
			start_q.vld <= in_fire;
			start_q.ch  <= nxt_ch_q;
			if (in_fire) begin
				busy_q   <= 1'b1;
				nxt_ch_q <= ~nxt_ch_q;
				en_q     <= en_q ^ button_pressed;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pass_q <= !(en_q ^ button_pressed);
			raw_q  <= smp;
			da_q   <= digital_a;
			db_q   <= digital_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (done) begin
				if (out_v_q && !out_ready) begin
					hold_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (hold_v_q && out_take) begin
				hold_v_q <= 1'b0;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (out_v_q && !out_ready) begin
				hold_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (hold_v_q && out_take) begin
			out_q <= hold_q;
		end
	end

	assign out_valid      = out_v_q;
	assign frame_first    = out_q.f1;
	assign frame_second   = out_q.f2;
	assign frame_third    = out_q.f3;
	assign filtered_value = out_q.value;
	assign channel_out    = out_q.ch;

endmodule
`default_nettype wire

@@ rtl/dcff_checker.sv @@
`default_nettype none
module dcff_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [7:0]        frame_first,
	input wire logic [7:0]        frame_second,
	input wire logic [7:0]        frame_third,
	input wire logic signed [15:0] filtered_value,
	input wire logic              channel_out
);

	// one item in the filter at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in the filter");

	a_sync_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_first[7] && frame_second[7:6] == 2'b10
			&& frame_third[7:6] == 2'b01)
		else $error("frame sync pattern wrong");

	a_frame_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_first[6] == channel_out
			&& frame_first[3:0] == filtered_value[15:12]
			&& frame_second[5:0] == filtered_value[11:6]
			&& frame_third[5:0] == filtered_value[5:0])
		else $error("frame does not match value or channel");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_value)
			&& $stable(channel_out))
		else $error("stalled result changed");

endmodule

bind dual_channel_fir_framer_unit dcff_checker u_dcff_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.frame_first    (frame_first),
	.frame_second   (frame_second),
	.frame_third    (frame_third),
	.filtered_value (filtered_value),
	.channel_out    (channel_out)
);
`default_nettype wire

@@ verif/dcff_frame_checker.sv @@
`timescale 1ns / 1ps
module dcff_frame_checker #(
	parameter int TAPS        = 26,
	parameter int SAMPLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         sample,
	input  logic               button_pressed,
	input  logic               digital_a,
	input  logic               digital_b,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         frame_first,
	input  logic [7:0]         frame_second,
	input  logic [7:0]         frame_third,
	input  logic signed [15:0] filtered_value,
	input  logic               channel_out,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [7:0]         first;
		logic [7:0]         second;
		logic [7:0]         third;
		logic signed [15:0] value;
		logic               ch;
	} frame_t;

	logic [SAMPLE_BITS-1:0] history [2][TAPS];
	int unsigned            head_idx [2];
	logic                   filter_on;
	logic                   turn;
	frame_t                 frames_due [$];
	int                     mismatches = 0;

	assign fail_count = mismatches;

	task automatic report(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %h, expected %h", field, got, want));
	endtask

	// shifts the sample into its channel's line, then filters (or passes raw) and frames
	function automatic frame_t filter_and_frame(input logic [7:0] raw, input logic btn,
			input logic da, input logic db);
		logic [SAMPLE_BITS-1:0] smp;
		logic                   ch;
		int unsigned            pos;
		int unsigned            tap_pos;
		int                     acc;
		logic [15:0]            value;
		frame_t                 f;
		smp = raw[SAMPLE_BITS-1:0];
		ch = turn;
		pos = head_idx[ch];
		history[ch][pos] = smp;
		head_idx[ch] = (pos == TAPS - 1) ? 0 : pos + 1;
		if (btn)
			filter_on = !filter_on;
		if (filter_on) begin
			acc = 0;
			tap_pos = pos;
			for (int j = 0; j < TAPS && j < dcff_pkg::COEF_SLOTS; j++) begin
				acc += int'(dcff_pkg::COEF_TABLE[j]) * int'(history[ch][tap_pos]);
				tap_pos = (tap_pos == 0) ? TAPS - 1 : tap_pos - 1;
			end
			if (acc > 32767)
				acc = 32767;
			if (acc < -32768)
				acc = -32768;
			value = acc[15:0];
		end else begin
			value = 16'(smp);
		end
		turn = ~ch;
		f.first  = {1'b1, ch, da, db, value[15:12]};
		f.second = {2'b10, value[11:6]};
		f.third  = {2'b01, value[5:0]};
		f.value  = value;
		f.ch     = ch;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frame_t due;
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				head_idx[c] = 0;
				for (int t = 0; t < TAPS; t++)
					history[c][t] = '0;
			end
			filter_on = 1'b1;
			turn = dcff_pkg::CH_X;
			frames_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					report("result transfer with no frame expected");
				end else begin
					due = frames_due.pop_front();
					check_field("frame_first", 16'(frame_first), 16'(due.first));
					check_field("frame_second", 16'(frame_second), 16'(due.second));
					check_field("frame_third", 16'(frame_third), 16'(due.third));
					check_field("filtered_value", filtered_value, due.value);
					check_field("channel_out", 16'(channel_out), 16'(due.ch));
				end
			end
			if (in_valid && in_ready)
				frames_due.push_back(filter_and_frame(sample, button_pressed,
					digital_a, digital_b));
			pending <= frames_due.size();
		end
	end

endmodule

@@ verif/tb_dual_channel_fir_framer_unit.sv @@
`timescale 1ns / 1ps
module tb_dual_channel_fir_framer_unit;

	localparam int          TAPS         = 26;
	localparam int          SAMPLE_BITS  = 8;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          N_RANDOM     = 1820;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 40;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic [7:0]         sample         = '0;
	logic               button_pressed = 1'b0;
	logic               digital_a      = 1'b0;
	logic               digital_b      = 1'b0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [7:0]         frame_first;
	logic [7:0]         frame_second;
	logic [7:0]         frame_third;
	logic signed [15:0] filtered_value;
	logic               channel_out;
	int                 fail_count;
	int                 pending;
	logic               quiet          = 1'b0;
	int                 hold_req       = 0;
	int unsigned        cycles         = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dual_channel_fir_framer_unit #(
		.TAPS       (TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.button_pressed(button_pressed),
		.digital_a     (digital_a),
		.digital_b     (digital_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_first   (frame_first),
		.frame_second  (frame_second),
		.frame_third   (frame_third),
		.filtered_value(filtered_value),
		.channel_out   (channel_out)
	);

	dcff_frame_checker #(
		.TAPS       (TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.button_pressed(button_pressed),
		.digital_a     (digital_a),
		.digital_b     (digital_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_first   (frame_first),
		.frame_second  (frame_second),
		.frame_third   (frame_third),
		.filtered_value(filtered_value),
		.channel_out   (channel_out),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure, plus a long hold-off on request
	initial begin : frame_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	task automatic offer_sample(input logic [7:0] s, input logic b, input logic da,
			input logic db);
		while (!quiet && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sample         <= s;
		button_pressed <= b;
		digital_a      <= da;
		digital_b      <= db;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin : sample_source
		logic [7:0] s;
		int         kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_sample(8'h00, 1'b0, 1'b0, 1'b0);
		offer_sample(8'h00, 1'b0, 1'b1, 1'b1);
		// full-scale run on both channels until the sum saturates
		for (int k = 0; k < 26; k++)
			offer_sample(8'hFF, 1'b0, k[0], k[1]);
		// filter off: raw pass-through, history still written
		offer_sample(8'hFF, 1'b1, 1'b1, 1'b0);
		offer_sample(8'h00, 1'b0, 1'b0, 1'b1);
		offer_sample(8'h80, 1'b1, 1'b1, 1'b1);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 400)
				quiet <= 1'b1;
			if (i == 750)
				quiet <= 1'b0;
			if (i == 1000)
				hold_req <= hold_req + 1;
			if (i == 1300) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: s = 8'h00;
				1: s = 8'hFF;
				2: s = 8'($urandom_range(0, 15));
				3: s = 8'($urandom_range(240, 255));
				default: s = 8'($urandom);
			endcase
			offer_sample(s, $urandom_range(0, 15) == 0, 1'($urandom), 1'($urandom));
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
